[src/bit_pool_field_access_assert.svh]
//------------------------------------------------------------------------------
// Assertion macros for the bit pool field access block
// Implication checks with a reset guard, same-cycle and next-cycle forms.
//------------------------------------------------------------------------------
`ifndef BIT_POOL_FIELD_ACCESS_ASSERT_SVH
`define BIT_POOL_FIELD_ACCESS_ASSERT_SVH

// ante holds -> cons holds in the same cycle
`define BPFA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// ante holds -> cons holds in the next cycle
`define BPFA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/bpfa_pkg.sv]
//------------------------------------------------------------------------------
// bpfa_pkg
// Shared types and constants of the bit pool field access block.
//------------------------------------------------------------------------------
package bpfa_pkg;

   localparam int POOL_BYTES  = 512;
   localparam int POOL_BITS   = POOL_BYTES * 8;
   localparam int OFFSET_W    = 12;
   localparam int LEN_W       = 7;
   localparam int WORD_BITS   = 64;
   localparam int WORD_SHIFT  = $clog2(WORD_BITS);
   localparam int WORD_IDX_W  = OFFSET_W - WORD_SHIFT;
   localparam int BANK_AW     = WORD_IDX_W - 1;
   localparam int BANK_DEPTH  = 2 ** BANK_AW;
   localparam int NUM_WORDS   = (POOL_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int RANGE_W     = OFFSET_W + 1;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_SET   = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_WAS_SET   = 2'd1,
      ST_WAS_CLEAR = 2'd2,
      ST_RANGE     = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      op_type                 kind;
      logic [OFFSET_W-1:0]    offset;
      logic [LEN_W-1:0]       len;
      logic [WORD_BITS-1:0]   wval;
   } request_type;

   typedef struct packed {
      logic [WORD_BITS-1:0]   read_value;
      status_type             status;
      logic                   write_en;
   } result_type;

   // True if a word index lies inside the pool.
   function automatic logic word_exists(input logic [WORD_IDX_W:0] idx);
      return 32'(idx) < 32'(NUM_WORDS);
   endfunction

endpackage

[src/bpfa_bank.sv]
//------------------------------------------------------------------------------
// bpfa_bank
// One bank of pool words: synchronous memory with registered read data and a
// valid bit per entry so that reset reads back as zero at once.
//------------------------------------------------------------------------------
`include "bit_pool_field_access_assert.svh"

module bpfa_bank (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               rd_en,
   input  logic [bpfa_pkg::BANK_AW-1:0]       rd_addr,
   output logic [bpfa_pkg::WORD_BITS-1:0]     rd_data,
   input  logic                               wr_en,
   input  logic [bpfa_pkg::BANK_AW-1:0]       wr_addr,
   input  logic [bpfa_pkg::WORD_BITS-1:0]     wr_data
);

   logic [bpfa_pkg::WORD_BITS-1:0]  mem [bpfa_pkg::BANK_DEPTH];
   logic [bpfa_pkg::BANK_DEPTH-1:0] valid_ff;
   logic [bpfa_pkg::WORD_BITS-1:0]  rd_word_ff;
   logic                            rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_word_ff <= mem[rd_addr];
         rd_vld_ff  <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // never-written entries read as zero
   assign rd_data = rd_vld_ff ? rd_word_ff : '0;

   `BPFA_ASSERT_NOW(a_no_rw_overlap, clock, reset, rd_en, !wr_en,
      "bank read and write in the same cycle")
   `BPFA_ASSERT_NEXT(a_wr_marks_valid, clock, reset, wr_en, valid_ff[$past(wr_addr)],
      "written entry not marked valid")
   `BPFA_ASSERT_NEXT(a_invalid_reads_zero, clock, reset, rd_en && !valid_ff[rd_addr],
      rd_data == '0, "unwritten entry did not read as zero")

endmodule

[src/bpfa_merge.sv]
//------------------------------------------------------------------------------
// bpfa_merge
// Field extract and insert over a pair of adjacent pool words, plus range
// check and status.
//------------------------------------------------------------------------------
module bpfa_merge (
   input  bpfa_pkg::request_type                  req,
   input  logic [2*bpfa_pkg::WORD_BITS-1:0]       pair,
   output logic [2*bpfa_pkg::WORD_BITS-1:0]       new_pair,
   output bpfa_pkg::result_type                   res
);

   localparam int PW = 2 * bpfa_pkg::WORD_BITS;
   localparam int WB = bpfa_pkg::WORD_BITS;

   logic [bpfa_pkg::WORD_SHIFT-1:0] pos;
   logic                            single;
   logic                            in_range;
   logic [bpfa_pkg::RANGE_W-1:0]    end_bit;
   logic [bpfa_pkg::LEN_W-1:0]      eff_len;
   logic [WB-1:0]                   eff_val;
   logic [WB-1:0]                   mask;
   logic [bpfa_pkg::LEN_W:0]        ins_shift;
   logic [PW-1:0]                   mask_wide;
   logic [PW-1:0]                   val_wide;
   logic [PW-1:0]                   aligned;
   logic [bpfa_pkg::LEN_W-1:0]      ext_shift;
   logic [WB-1:0]                   field;
   logic                            cur_bit;

   always_comb begin
      pos     = req.offset[bpfa_pkg::WORD_SHIFT-1:0];
      single  = (req.kind == bpfa_pkg::OP_SET) || (req.kind == bpfa_pkg::OP_CLEAR);
      end_bit = {1'b0, req.offset} + bpfa_pkg::RANGE_W'(req.len);

      if (single) begin
         in_range = 32'(req.offset) < 32'(bpfa_pkg::POOL_BITS);
      end else begin
         in_range = (req.len != '0) && (32'(req.len) <= 32'(WB)) &&
                    (32'(end_bit) <= 32'(bpfa_pkg::POOL_BITS));
      end

      eff_len = single ? bpfa_pkg::LEN_W'(1) : req.len;
      eff_val = single ? WB'(req.kind == bpfa_pkg::OP_SET) : req.wval;
      // a length of a full word shifts the one out and wraps to all ones
      mask    = (WB'(1) << eff_len) - WB'(1);

      // insert: field MSB lands at bit pos counted from the pair's MSB
      ins_shift = (bpfa_pkg::LEN_W + 1)'(PW) - (bpfa_pkg::LEN_W + 1)'(pos)
                  - (bpfa_pkg::LEN_W + 1)'(eff_len);
      mask_wide = {{WB{1'b0}}, mask} << ins_shift[bpfa_pkg::LEN_W-1:0];
      val_wide  = {{WB{1'b0}}, eff_val & mask} << ins_shift[bpfa_pkg::LEN_W-1:0];
      new_pair  = (pair & ~mask_wide) | val_wide;

      // extract: left-align at pos, then right-align the field
      aligned   = pair << pos;
      ext_shift = bpfa_pkg::LEN_W'(WB) - eff_len;
      field     = aligned[PW-1 -: WB] >> ext_shift;
      cur_bit   = aligned[PW-1];

      res.write_en   = in_range && (req.kind != bpfa_pkg::OP_READ);
      res.read_value = (in_range && (req.kind == bpfa_pkg::OP_READ)) ? field : '0;
      if (!in_range) begin
         res.status = bpfa_pkg::ST_RANGE;
      end else if ((req.kind == bpfa_pkg::OP_SET) && cur_bit) begin
         res.status = bpfa_pkg::ST_WAS_SET;
      end else if ((req.kind == bpfa_pkg::OP_CLEAR) && !cur_bit) begin
         res.status = bpfa_pkg::ST_WAS_CLEAR;
      end else begin
         res.status = bpfa_pkg::ST_OK;
      end
   end

endmodule

[src/bit_pool_field_access.sv]
//------------------------------------------------------------------------------
// bit_pool_field_access
// Bit-addressed pool with field read/write and single-bit set/clear.
//------------------------------------------------------------------------------
// A request is registered on transfer while both pool banks read its words; no
//   new request is taken until it finishes, by the read-then-write of the banks
//   (read on accept, modify and write once the response slot is free).
// A stalled response holds the block in its execute cycle until it drains.
// Reset (synchronous, active high) clears the per-word valid bits at once, so
//   the pool reads as all zero with no clearing pass.
//------------------------------------------------------------------------------
`include "bit_pool_field_access_assert.svh"

module bit_pool_field_access (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_type,
   input  logic [bpfa_pkg::OFFSET_W-1:0]       req_bit_offset,
   input  logic [bpfa_pkg::LEN_W-1:0]          req_field_bits,
   input  logic [bpfa_pkg::WORD_BITS-1:0]      req_write_value,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [bpfa_pkg::WORD_BITS-1:0]      rsp_read_value,
   output logic [1:0]                          rsp_status
);

   localparam int WB = bpfa_pkg::WORD_BITS;
   localparam int IW = bpfa_pkg::WORD_IDX_W;
   localparam int AW = bpfa_pkg::BANK_AW;

   bpfa_pkg::state_type   state_ff, state_in;
   bpfa_pkg::request_type req_ff;
   bpfa_pkg::result_type  res;

   logic                  accept;
   logic                  slot_free;
   logic                  finish;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WB-1:0]         rsp_value_ff;
   bpfa_pkg::status_type  rsp_status_ff;

   // word addressing for the new request (read side) and held request (write side)
   logic [IW-1:0]         rd_w0;
   logic [IW:0]           rd_even_idx;
   logic [IW:0]           rd_odd_idx;
   logic [IW-1:0]         ex_w0;
   logic [IW:0]           ex_even_idx;
   logic [IW:0]           ex_odd_idx;
   logic                  even_exists;
   logic                  odd_exists;

   logic [WB-1:0]         even_rd_data;
   logic [WB-1:0]         odd_rd_data;
   logic [WB-1:0]         even_word;
   logic [WB-1:0]         odd_word;
   logic [2*WB-1:0]       pair;
   logic [2*WB-1:0]       new_pair;
   logic [WB-1:0]         even_wr_data;
   logic [WB-1:0]         odd_wr_data;

   //---------------------------------------------------------------------------
   // Control: accept in idle, execute once the response slot is free
   //---------------------------------------------------------------------------
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bpfa_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = bpfa_pkg::S_EXEC;
            end
         end
         bpfa_pkg::S_EXEC: begin
            if (slot_free) begin
               state_in = bpfa_pkg::S_IDLE;
            end
         end
         default: state_in = bpfa_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      finish    = 1'b0;
      unique case (state_ff)
         bpfa_pkg::S_IDLE: req_stall = 1'b0;
         bpfa_pkg::S_EXEC: finish    = slot_free;
         default: begin
            req_stall = 1'b1;
            finish    = 1'b0;
         end
      endcase
   end

   assign accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bpfa_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // hold the request for the execute cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff.kind   <= bpfa_pkg::op_type'(req_type);
         req_ff.offset <= req_bit_offset;
         req_ff.len    <= req_field_bits;
         req_ff.wval   <= req_write_value;
      end
   end

   //---------------------------------------------------------------------------
   // Bank addressing: even words in one bank, odd in the other, so the two
   // words a field can span always sit in different banks.
   //---------------------------------------------------------------------------
   always_comb begin
      rd_w0       = req_bit_offset[bpfa_pkg::OFFSET_W-1 -: IW];
      rd_even_idx = {1'b0, rd_w0} + (IW + 1)'(rd_w0[0]);
      rd_odd_idx  = {1'b0, rd_w0[IW-1:1], 1'b1};

      ex_w0       = req_ff.offset[bpfa_pkg::OFFSET_W-1 -: IW];
      ex_even_idx = {1'b0, ex_w0} + (IW + 1)'(ex_w0[0]);
      ex_odd_idx  = {1'b0, ex_w0[IW-1:1], 1'b1};
      even_exists = bpfa_pkg::word_exists(ex_even_idx);
      odd_exists  = bpfa_pkg::word_exists(ex_odd_idx);

      // words past the end of the pool read as zero
      even_word = even_exists ? even_rd_data : '0;
      odd_word  = odd_exists  ? odd_rd_data  : '0;
      // first word of the span is the upper half of the pair
      pair = ex_w0[0] ? {odd_word, even_word} : {even_word, odd_word};

      even_wr_data = ex_w0[0] ? new_pair[WB-1:0]  : new_pair[2*WB-1:WB];
      odd_wr_data  = ex_w0[0] ? new_pair[2*WB-1:WB] : new_pair[WB-1:0];
   end

   bpfa_bank u_even_bank (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept && bpfa_pkg::word_exists(rd_even_idx)),
      .rd_addr (rd_even_idx[AW:1]),
      .rd_data (even_rd_data),
      .wr_en   (finish && res.write_en && even_exists),
      .wr_addr (ex_even_idx[AW:1]),
      .wr_data (even_wr_data)
   );

   bpfa_bank u_odd_bank (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept && bpfa_pkg::word_exists(rd_odd_idx)),
      .rd_addr (rd_odd_idx[AW:1]),
      .rd_data (odd_rd_data),
      .wr_en   (finish && res.write_en && odd_exists),
      .wr_addr (ex_odd_idx[AW:1]),
      .wr_data (odd_wr_data)
   );

   bpfa_merge u_merge (
      .req      (req_ff),
      .pair     (pair),
      .new_pair (new_pair),
      .res      (res)
   );

   //---------------------------------------------------------------------------
   // Response register: load on finish, hold while stalled
   //---------------------------------------------------------------------------
   assign rsp_valid_in = finish || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_value_ff  <= res.read_value;
         rsp_status_ff <= res.status;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;

   `BPFA_ASSERT_NEXT(a_accept_blocks, clock, reset, accept, req_stall,
      "request transfer did not block the next one")
   `BPFA_ASSERT_NEXT(a_exec_waits, clock, reset,
      (state_ff == bpfa_pkg::S_EXEC) && rsp_valid_ff && rsp_stall,
      state_ff == bpfa_pkg::S_EXEC, "execute left while response slot was full")
   `BPFA_ASSERT_NOW(a_range_zero, clock, reset,
      rsp_valid && (rsp_status == bpfa_pkg::ST_RANGE), rsp_read_value == '0,
      "out-of-range response carries a nonzero value")

endmodule

[bench/tb.sv]
//------------------------------------------------------------------------------
// tb: testbench of bit_pool_field_access
// Drives field reads, field writes and single-bit set/clear requests through
// the valid/stall request channel, predicts every response from a private
// bit-level copy of the pool, and checks each response transfer in order.
//------------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bpfa_pkg::*;

   localparam int CYCLE_LIMIT  = 400_000;
   localparam int RANDOM_ITEMS = 467;   // per idling phase, three phases
   localparam int DRAIN_CYCLES = 8;     // idle wait after the last expected response

   // One expected response.
   typedef struct {
      logic [WORD_BITS-1:0] read_value;
      status_type           status;
   } pool_response;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_type = OP_READ;
   logic [OFFSET_W-1:0]  req_bit_offset = '0;
   logic [LEN_W-1:0]     req_field_bits = '0;
   logic [WORD_BITS-1:0] req_write_value = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [WORD_BITS-1:0] rsp_read_value;
   logic [1:0]           rsp_status;

   // Shadow of the pool: index n is bit n, i.e. bit 7 - n%8 of byte n/8.
   bit                   pool_shadow [POOL_BITS];

   request_type          pending_reqs [$];
   pool_response         expected_rsps [$];
   int unsigned          send_idle_pct = 7;
   int unsigned          recv_stall_pct = 58;
   int unsigned          mismatch_count = 0;
   int unsigned          cycle_count = 0;

   bit_pool_field_access u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_bit_offset  (req_bit_offset),
      .req_field_bits  (req_field_bits),
      .req_write_value (req_write_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Hold reset from the start, then release it for good.
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // Apply one request to the shadow pool and return the response it must give.
   function automatic pool_response access_pool(input op_type kind,
                                                input logic [OFFSET_W-1:0] off,
                                                input logic [LEN_W-1:0] len,
                                                input logic [WORD_BITS-1:0] wval);
      pool_response r;
      int           pos;
      int           n;
      pos          = int'(off);
      n            = int'(len);
      r.read_value = '0;
      r.status     = ST_OK;
      if (kind == OP_SET || kind == OP_CLEAR) begin
         // field length plays no part in single-bit requests
         if (pos >= POOL_BITS)
            r.status = ST_RANGE;
         else if (kind == OP_SET) begin
            if (pool_shadow[pos])
               r.status = ST_WAS_SET;
            else
               pool_shadow[pos] = 1'b1;
         end else begin
            if (!pool_shadow[pos])
               r.status = ST_WAS_CLEAR;
            else
               pool_shadow[pos] = 1'b0;
         end
      end else if (n == 0 || n > WORD_BITS || pos + n > POOL_BITS) begin
         // bad length or a field that runs off the end: flag it, touch nothing
         r.status = ST_RANGE;
      end else if (kind == OP_READ) begin
         // first bit of the field lands in the most significant used position
         for (int i = 0; i < n; i++)
            r.read_value = {r.read_value[WORD_BITS-2:0], pool_shadow[pos + i]};
      end else begin
         // bits of the write value at or above the field length are dropped
         for (int i = 0; i < n; i++)
            pool_shadow[pos + i] = wval[n - 1 - i];
      end
      return r;
   endfunction

   task automatic queue_request(input op_type kind, input int off, input int len,
                                input logic [WORD_BITS-1:0] wval);
      request_type q;
      q.kind   = kind;
      q.offset = OFFSET_W'(off);
      q.len    = LEN_W'(len);
      q.wval   = wval;
      pending_reqs.push_back(q);
   endtask

   // Mostly well-formed requests, with offsets bunched into a low window and
   // near the end of the pool so that set/clear hit earlier writes and fields
   // straddle the last word; about one in ten has a bad length.
   task automatic queue_random_request();
      int          sel;
      int          off;
      int          len;
      op_type      kind;
      kind = op_type'($urandom_range(3));
      sel  = $urandom_range(99);
      if (sel < 40)
         off = $urandom_range(POOL_BITS - 1);
      else if (sel < 75)
         off = $urandom_range(255);
      else
         off = $urandom_range(POOL_BITS - 1, POOL_BITS - 106);
      sel = $urandom_range(99);
      if (sel < 80)
         len = $urandom_range(WORD_BITS, 1);
      else if (sel < 90)
         len = $urandom_range(1) ? WORD_BITS : 1;
      else if (sel < 93)
         len = 0;
      else
         len = $urandom_range(2 ** LEN_W - 1, WORD_BITS + 1);
      queue_request(kind, off, len, {$urandom, $urandom});
   endtask

   // Short directed opening: extremes, every request type, every status.
   task automatic queue_directed_requests();
      queue_request(OP_READ,  0,    64,  '0);
      queue_request(OP_WRITE, 0,    64,  '1);
      queue_request(OP_READ,  0,    64,  '0);
      queue_request(OP_CLEAR, 0,    1,   '0);
      queue_request(OP_CLEAR, 0,    1,   '0);   // already clear
      queue_request(OP_SET,   0,    1,   '0);
      queue_request(OP_SET,   0,    1,   '0);   // already set
      queue_request(OP_SET,   4095, 0,   '1);   // last bit, length ignored
      queue_request(OP_SET,   4095, 127, '0);
      queue_request(OP_CLEAR, 4095, 64,  '1);
      queue_request(OP_READ,  4032, 64,  '0);   // ends exactly at the last bit
      queue_request(OP_READ,  4033, 64,  '0);   // one bit past the end
      queue_request(OP_WRITE, 4095, 2,   '1);   // runs off the end
      queue_request(OP_WRITE, 4095, 1,   64'h1);
      queue_request(OP_READ,  4095, 1,   '0);
      queue_request(OP_READ,  10,   0,   '0);   // zero length
      queue_request(OP_READ,  10,   65,  '0);   // one too long
      queue_request(OP_WRITE, 100,  127, '1);   // longest encodable length
      queue_request(OP_WRITE, 200,  5,   64'hFFFF_FFFF_FFFF_FFE5);   // upper bits dropped
      queue_request(OP_READ,  198,  9,   '0);
      queue_request(OP_WRITE, 61,   64,  64'hA5C3_0F96_1E2D_7B48);   // straddles words
      queue_request(OP_READ,  61,   64,  '0);
      queue_request(OP_READ,  60,   3,   '0);
   endtask

   // Request driver: on a transfer, predict its response, then present the
   // next pending request or go idle. A stalled request is held unchanged.
   always @(posedge clock) begin
      request_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid)
            expected_rsps.push_back(access_pool(op_type'(req_type), req_bit_offset,
                                                req_field_bits, req_write_value));
         if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = pending_reqs.pop_front();
            req_valid       <= 1'b1;
            req_type        <= nxt.kind;
            req_bit_offset  <= nxt.offset;
            req_field_bits  <= nxt.len;
            req_write_value <= nxt.wval;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response side backpressure.
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Response monitor: compare every transfer against the oldest prediction.
   always @(posedge clock) begin
      pool_response exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: response with nothing outstanding: read_value %h status %0d",
                     $time, rsp_read_value, rsp_status);
            mismatch_count++;
         end else begin
            exp_rsp = expected_rsps.pop_front();
            if (rsp_read_value !== exp_rsp.read_value) begin
               $display("%0t: read_value mismatch: expected %h, actual %h",
                        $time, exp_rsp.read_value, rsp_read_value);
               mismatch_count++;
            end
            if (rsp_status !== exp_rsp.status) begin
               $display("%0t: status mismatch: expected %0d, actual %0d",
                        $time, exp_rsp.status, rsp_status);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Sequence the three idling phases, then drain and report.
   initial begin
      for (int phase = 0; phase < 3; phase++) begin
         @(negedge clock);
         case (phase)
            0: begin
               send_idle_pct  = 7;
               recv_stall_pct = 58;
               queue_directed_requests();
            end
            1: begin
               send_idle_pct  = 58;
               recv_stall_pct = 7;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
         endcase
         repeat (RANDOM_ITEMS) queue_random_request();
         // wait until every request has transferred and every response is in
         while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
            @(negedge clock);
      end
      // leave room for any stray response to show up
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
